FILE: rtl/dctq_pkg.sv
// Shared constants, types and constant tables of the 8x8 DCT quantizer.
`timescale 1ns / 1ps
`default_nettype none
package dctq_pkg;

  localparam int COEF_FRACTION_BITS = 14;
  localparam int MID_FRAC = 4;
  localparam int COEF_W = COEF_FRACTION_BITS + 1;
  localparam int PASS_W = 26;
  localparam int ACC_W = COEF_FRACTION_BITS + 28;
  localparam int BLK_W = 12;
  localparam int DIV_W = 14;
  localparam int STEP_W = 8;

  typedef enum logic [1:0] {
    CFG_QUALITY = 2'd0,
    CFG_TABLE   = 2'd1,
    CFG_DIR     = 2'd2
  } dctq_cfg_idx_t;

  typedef struct packed {
    logic              go;
    logic [DIV_W-1:0]  num;
    logic [STEP_W-1:0] den;
  } dctq_div_req_t;

  localparam logic [31:0] HALF_COS30 [0:8] = '{
    32'd536870912, 32'd526555088, 32'd496004047, 32'd446391849, 32'd379625062,
    32'd298269498, 32'd205451603, 32'd104738319, 32'd0
  };

  localparam logic [6:0] BASE_LUMA [0:63] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [6:0] BASE_CHROMA [0:63] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  function automatic logic [6:0] dctq_base(input logic sel, input logic [5:0] idx);
    return sel ? BASE_CHROMA[idx] : BASE_LUMA[idx];
  endfunction

  // DCT matrix entry C[u][x], signed with COEF_FRACTION_BITS fraction bits
  function automatic logic signed [COEF_W-1:0] dctq_coef(input logic [2:0] u,
                                                          input logic [2:0] x);
    logic [7:0]  prod;
    logic [4:0]  k;
    logic        neg;
    logic [31:0] m;
    prod = 8'({x, 1'b1}) * 8'(u);
    k = prod[4:0];
    neg = 1'b0;
    if (k > 5'd16) k = 5'(6'd32 - {1'b0, k});
    if (k > 5'd8) begin
      k = 5'd16 - k;
      neg = 1'b1;
    end
    m = (u == 3'd0) ? HALF_COS30[4] : HALF_COS30[k[3:0]];
    m = (m + (32'd1 << (29 - COEF_FRACTION_BITS))) >> (30 - COEF_FRACTION_BITS);
    return neg ? -$signed(COEF_W'(m)) : $signed(COEF_W'(m));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dctq_div.sv
// Restoring divider, one quotient bit per cycle, shared by step build and quantize.
`timescale 1ns / 1ps
`default_nettype none
module dctq_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dctq_pkg::dctq_div_req_t       req,
  output logic                               done,
  output logic [dctq_pkg::DIV_W-1:0]         quo
);
  import dctq_pkg::*;

  logic [STEP_W-1:0] rem_r;
  logic [STEP_W-1:0] den_r;
  logic [DIV_W-1:0]  quo_r;
  logic [3:0]        cnt_r;
  logic              done_r;
  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.go) begin
      cnt_r  <= 4'(DIV_W);
      done_r <= 1'b0;
    end else begin
      if (cnt_r != 4'd0) cnt_r <= cnt_r - 4'd1;
      done_r <= (cnt_r == 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= '0;
      den_r <= req.den;
      quo_r <= req.num;
    end else if (cnt_r != 4'd0) begin
      rem_r <= fits ? STEP_W'(trial - {1'b0, den_r}) : STEP_W'(trial);
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

FILE: rtl/dct8x8_quantizer_codec.sv
// Top level of the 8x8 DCT quantizer / dequantizer with a shared MAC sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Input: one element per transfer when start is high and busy is low, 64 per
//  block in raster order. direction 0 takes in_sample, 1 takes in_coefficient_in.
//  Output: after the 64th element the block computes two 8-tap passes over the
//  block with one multiply-accumulate pipeline (one product per cycle) and emits
//  64 results in raster order, each for one cycle under out_strobe,
//  out_last_of_block on the last. busy stays high.
//  Forward mode adds a serial divide per result for quantizing; inverse mode
//  has no divide.
//  Config: cfg_we with cfg_index/cfg_data. A quality or table write rebuilds the
//  step table with the serial divider, one step at a time, with busy high; a
//  direction write drops a partly loaded block.
//  Reset: registers return to quality 50, luma, forward, and the step table is
//  built right after reset, with busy high.
//  The receiver cannot stall: every result is a one-cycle transfer.
module dct8x8_quantizer_codec (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [7:0]         in_sample,
  input  wire logic signed [11:0] in_coefficient_in,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_data,
  output logic                    out_strobe,
  output logic signed [11:0]      out_coefficient_out,
  output logic [7:0]              out_pixel_out,
  output logic [5:0]              out_position,
  output logic                    out_last_of_block
);
  import dctq_pkg::*;

  typedef enum logic [6:0] {
    ST_BUILD = 7'b0000001,
    ST_BWAIT = 7'b0000010,
    ST_IDLE  = 7'b0000100,
    ST_MAC   = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_QDIV  = 7'b1000000
  } dctq_state_t;

  localparam int F = COEF_FRACTION_BITS;

  dctq_state_t state_r, state_nxt;
  logic [5:0]  bi_r, bi_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  p_r, p_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        pass2_r, pass2_nxt;
  logic [6:0]  quality_r;
  logic        tsel_r;
  logic        dir_r;
  logic        adv;
  logic        blk_we, step_we, pass_we, out_fire;

  logic signed [BLK_W-1:0]  blk_mem [0:63];
  logic signed [PASS_W-1:0] pass_mem [0:63];
  logic [STEP_W-1:0]        step_mem [0:63];
  logic signed [BLK_W-1:0]  blk_q;
  logic signed [PASS_W-1:0] pas_q;
  logic [STEP_W-1:0]        step_q;
  logic [5:0]               step_raddr;

  logic                     v1_r, v2_r, v3_r;
  logic signed [COEF_W-1:0] coef1_r, coef2_r, coef_sel;
  logic signed [PASS_W-1:0] a_r;
  logic signed [PASS_W+COEF_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [2:0]               rsel;

  dctq_div_req_t     div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic              qneg_r;

  // step build arithmetic
  logic [6:0]        qe;
  logic [6:0]        bval;
  logic [DIV_W-1:0]  num_hi, num_lo;
  logic [STEP_W-1:0] step_new;

  // finalize arithmetic
  logic                    acc_neg;
  logic [ACC_W-1:0]        acc_mag, rnd1, rnd2, tq;
  logic signed [ACC_W-1:0] pv;
  logic signed [PASS_W-1:0] pass_val;
  logic [7:0]              pix_val;
  logic signed [11:0]      q_val;

  dctq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (quality_r == 7'd0) qe = 7'd1;
    else if (quality_r > 7'd100) qe = 7'd100;
    else qe = quality_r;
    bval   = dctq_base(tsel_r, bi_r);
    num_hi = DIV_W'({7'b0, bval} * {7'b0, 7'd100 - qe}) + DIV_W'(25);
    num_lo = DIV_W'({7'b0, bval} * 14'd100) + DIV_W'(qe);
    if (div_quo == '0) step_new = 8'd1;
    else if (div_quo > DIV_W'(255)) step_new = 8'd255;
    else step_new = div_quo[STEP_W-1:0];
  end

  always_comb begin
    acc_neg  = acc_r[ACC_W-1];
    acc_mag  = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    rnd1     = (acc_mag + (ACC_W'(1) << (F - MID_FRAC - 1))) >> (F - MID_FRAC);
    pass_val = acc_neg ? -$signed(PASS_W'(rnd1)) : $signed(PASS_W'(rnd1));
    rnd2     = (acc_mag + (ACC_W'(1) << (F + MID_FRAC - 1))) >> (F + MID_FRAC);
    pv       = (acc_neg ? -$signed(rnd2) : $signed(rnd2)) + $signed(ACC_W'(128));
    if (pv < 0) pix_val = 8'd0;
    else if (pv > $signed(ACC_W'(255))) pix_val = 8'd255;
    else pix_val = pv[7:0];
    tq = (acc_mag + (ACC_W'(step_q) << (F + MID_FRAC - 1))) >> (F + MID_FRAC);
    if (!qneg_r) q_val = (div_quo > DIV_W'(2047)) ? 12'sd2047 : $signed(div_quo[11:0]);
    else if (div_quo > DIV_W'(2048)) q_val = -12'sd2048;
    else q_val = $signed(12'(-div_quo[11:0]));
  end

  always_comb begin
    state_nxt = state_r;
    bi_nxt    = bi_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    pass2_nxt = pass2_r;
    div_req   = '0;
    blk_we    = 1'b0;
    step_we   = 1'b0;
    pass_we   = 1'b0;
    out_fire  = 1'b0;
    adv       = 1'b0;
    case (state_r)
      ST_BUILD: begin
        div_req.go  = 1'b1;
        div_req.num = (qe >= 7'd51) ? num_hi : num_lo;
        div_req.den = (qe >= 7'd51) ? 8'd50 : {qe, 1'b0};
        state_nxt   = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (div_done) begin
          step_we = 1'b1;
          if (bi_r == 6'd63) begin
            state_nxt = ST_IDLE;
          end else begin
            bi_nxt    = bi_r + 6'd1;
            state_nxt = ST_BUILD;
          end
        end
      end
      ST_IDLE: begin
        if (start) begin
          blk_we  = 1'b1;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            p_nxt     = '0;
            k_nxt     = '0;
            pass2_nxt = 1'b0;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(v1_r || v2_r || v3_r)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!pass2_r) begin
          pass_we = 1'b1;
          adv     = 1'b1;
        end else if (dir_r) begin
          out_fire = 1'b1;
          adv      = 1'b1;
        end else begin
          div_req.go  = 1'b1;
          div_req.num = tq[DIV_W-1:0];
          div_req.den = step_q;
          state_nxt   = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (div_done) begin
          out_fire = 1'b1;
          adv      = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) begin
      k_nxt = '0;
      if (p_r == 6'd63) begin
        p_nxt = '0;
        if (pass2_r) begin
          state_nxt = ST_IDLE;
        end else begin
          pass2_nxt = 1'b1;
          state_nxt = ST_MAC;
        end
      end else begin
        p_nxt     = p_r + 6'd1;
        state_nxt = ST_MAC;
      end
    end
    if (cfg_we) begin
      if (cfg_index == CFG_QUALITY || cfg_index == CFG_TABLE) begin
        state_nxt = ST_BUILD;
        bi_nxt    = '0;
      end
      if (cfg_index == CFG_DIR) cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_BUILD;
      bi_r      <= '0;
      cnt_r     <= '0;
      p_r       <= '0;
      k_r       <= '0;
      pass2_r   <= 1'b0;
      quality_r <= 7'd50;
      tsel_r    <= 1'b0;
      dir_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bi_r    <= bi_nxt;
      cnt_r   <= cnt_nxt;
      p_r     <= p_nxt;
      k_r     <= k_nxt;
      pass2_r <= pass2_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUALITY: quality_r <= cfg_data;
          CFG_TABLE:   tsel_r    <= cfg_data[0];
          CFG_DIR:     dir_r     <= cfg_data[0];
          default:     ;
        endcase
      end
    end
  end

  // memories
  assign step_raddr = pass2_r ? p_r : {k_r, p_r[2:0]};

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[cnt_r] <= dir_r ? in_coefficient_in
                              : $signed(BLK_W'({4'b0, in_sample}) - BLK_W'(128));
    end
    if (pass_we) pass_mem[p_r] <= pass_val;
    if (step_we) step_mem[bi_r] <= step_new;
    blk_q  <= blk_mem[{k_r, p_r[2:0]}];
    pas_q  <= pass_mem[{p_r[5:3], k_r}];
    step_q <= step_mem[step_raddr];
  end

  // MAC pipeline: read, operand, product, accumulate
  assign rsel     = pass2_r ? p_r[2:0] : p_r[5:3];
  assign coef_sel = dir_r ? dctq_coef(k_r, rsel) : dctq_coef(rsel, k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_MAC);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    coef1_r <= coef_sel;
    coef2_r <= coef1_r;
    if (pass2_r) a_r <= pas_q;
    else if (dir_r) a_r <= PASS_W'(blk_q) * PASS_W'($signed({1'b0, step_q}));
    else a_r <= PASS_W'(blk_q);
    prod_r <= a_r * coef2_r;
    if (state_r == ST_MAC && k_r == 3'd0) acc_r <= '0;
    else if (v3_r) acc_r <= acc_r + ACC_W'(prod_r);
    if (state_r == ST_FIN) qneg_r <= acc_neg;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_position        <= p_r;
      out_last_of_block   <= (p_r == 6'd63);
      out_coefficient_out <= dir_r ? 12'sd0 : q_val;
      out_pixel_out       <= dir_r ? pix_val : 8'd0;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for dct8x8_quantizer_codec: directed and random 8x8 blocks.
`timescale 1ns / 1ps

class codec_scoreboard;
  typedef struct {
    logic signed [11:0] coef;
    logic [7:0]         pix;
    logic [5:0]         pos;
    logic               last;
  } block_result_t;

  int unsigned    quality_reg;
  bit             chroma_sel;
  bit             inverse_dir;
  int             elem_store [64];
  int unsigned    steps [64];
  int unsigned    loaded;
  block_result_t  pending [$];
  int             errors;

  function new();
    quality_reg = 50;
    chroma_sel = 0;
    inverse_dir = 0;
    loaded = 0;
    errors = 0;
    build_steps();
  endfunction

  function void build_steps();
    int unsigned q, b, s;
    q = quality_reg;
    if (q < 1) q = 1;
    if (q > 100) q = 100;
    for (int i = 0; i < 64; i++) begin
      b = chroma_sel ? dctq_pkg::BASE_CHROMA[i] : dctq_pkg::BASE_LUMA[i];
      if (q >= 51) s = (b * (100 - q) + 25) / 50;
      else s = (2 * b * 50 + q) / (2 * q);
      if (s < 1) s = 1;
      if (s > 255) s = 255;
      steps[i] = s;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [6:0] val);
    if (idx == dctq_pkg::CFG_QUALITY) begin
      quality_reg = val;
      build_steps();
    end else if (idx == dctq_pkg::CFG_TABLE) begin
      chroma_sel = val[0];
      build_steps();
    end else if (idx == dctq_pkg::CFG_DIR) begin
      inverse_dir = val[0];
      loaded = 0;
    end
  endfunction

  // cosine basis entry, 14 fraction bits, rounded from the 30-bit constant
  function longint basis(int u, int x);
    int k;
    bit neg;
    longint m;
    k = ((2 * x + 1) * u) & 31;
    neg = 0;
    if (k > 16) k = 32 - k;
    if (k > 8) begin
      k = 16 - k;
      neg = 1;
    end
    m = (u == 0) ? dctq_pkg::HALF_COS30[4] : dctq_pkg::HALF_COS30[k];
    m = (m + (64'd1 << (29 - 14))) >>> (30 - 14);
    return neg ? -m : m;
  endfunction

  function longint round_away(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function void note_input(logic [7:0] smp, logic signed [11:0] cin);
    elem_store[loaded] = inverse_dir ? int'(cin) : int'(smp) - 128;
    loaded++;
    if (loaded == 64) begin
      loaded = 0;
      transform_block();
    end
  endfunction

  function void transform_block();
    longint mid [64];
    longint acc, mag, den, v;
    block_result_t r;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        acc = 0;
        for (int k = 0; k < 8; k++)
          if (inverse_dir)
            acc += basis(k, i) * (longint'(elem_store[k*8+j]) * steps[k*8+j]);
          else
            acc += basis(i, k) * longint'(elem_store[k*8+j]);
        mid[i*8+j] = round_away(acc, 10);
      end
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        acc = 0;
        for (int k = 0; k < 8; k++)
          acc += mid[i*8+k] * (inverse_dir ? basis(k, j) : basis(j, k));
        r.coef = 0;
        r.pix = 0;
        if (inverse_dir) begin
          v = round_away(acc, 18) + 128;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          r.pix = v[7:0];
        end else begin
          den = longint'(steps[i*8+j]) << 18;
          mag = (acc < 0) ? -acc : acc;
          mag = (2 * mag + den) / (2 * den);
          if (mag > 4096) mag = 4096;
          v = (acc < 0) ? -mag : mag;
          if (v > 2047) v = 2047;
          if (v < -2048) v = -2048;
          r.coef = v[11:0];
        end
        r.pos = 6'(i * 8 + j);
        r.last = (i * 8 + j == 63);
        pending.push_back(r);
      end
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("%0t: mismatch %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task check(logic signed [11:0] coef, logic [7:0] pix, logic [5:0] pos, logic last);
    block_result_t e;
    if (pending.size() == 0) begin
      report_mismatch("unexpected result at position", pos, -1);
    end else begin
      e = pending.pop_front();
      if (coef !== e.coef) report_mismatch("coefficient_out", coef, e.coef);
      if (pix !== e.pix) report_mismatch("pixel_out", pix, e.pix);
      if (pos !== e.pos) report_mismatch("position", pos, e.pos);
      if (last !== e.last) report_mismatch("last_of_block", last, e.last);
    end
  endtask
endclass

module tb;
  import dctq_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // block content styles
  localparam int FILL_RANDOM  = 0;
  localparam int FILL_EXTREME = 1;
  localparam int FILL_SMALL   = 2;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic [7:0]         in_sample = 0;
  logic signed [11:0] in_coefficient_in = 0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = 0;
  logic [6:0]         cfg_data = 0;
  wire                busy;
  wire                out_strobe;
  wire signed [11:0]  out_coefficient_out;
  wire [7:0]          out_pixel_out;
  wire [5:0]          out_position;
  wire                out_last_of_block;
  bit                 steady;

  codec_scoreboard sb = new();

  dct8x8_quantizer_codec dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_coefficient_in(in_coefficient_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_coefficient_out(out_coefficient_out),
    .out_pixel_out(out_pixel_out), .out_position(out_position),
    .out_last_of_block(out_last_of_block)
  );

  always #5 clk = ~clk;

  always @(posedge clk)
    if (rst_n && out_strobe)
      sb.check(out_coefficient_out, out_pixel_out, out_position, out_last_of_block);

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [6:0] val);
    while (busy) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task send_item(logic [7:0] smp, logic signed [11:0] cin);
    int gap;
    start <= 1;
    in_sample <= smp;
    in_coefficient_in <= cin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(smp, cin);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_items(int count, int fill);
    logic [7:0] smp;
    logic signed [11:0] cin;
    for (int n = 0; n < count; n++) begin
      smp = 8'($urandom);
      cin = 12'($urandom);
      if (fill == FILL_EXTREME) begin
        smp = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        cin = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
      end else if (fill == FILL_SMALL) begin
        smp = 8'($urandom_range(100, 160));
        cin = $signed(12'($urandom_range(0, 40))) - 12'sd20;
      end
      send_item(smp, cin);
    end
    start <= 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // defaults, a partial block dropped by a direction write, an ignored index
    send_items(10, FILL_EXTREME);
    write_reg(CFG_DIR, 7'd0);
    write_reg(CFG_UNUSED, 7'd5);
    send_items(64, FILL_RANDOM);
    wait_idle();
    write_reg(CFG_QUALITY, 7'd1);
    write_reg(CFG_TABLE, 7'd1);
    steady = 1;
    send_items(64, FILL_EXTREME);
    steady = 0;
    wait_idle();
    // quality above 100 acts as 100: every step is 1
    write_reg(CFG_QUALITY, 7'd127);
    write_reg(CFG_DIR, 7'd1);
    send_items(64, FILL_SMALL);
    wait_idle();
    write_reg(CFG_QUALITY, 7'd0);
    write_reg(CFG_TABLE, 7'd0);
    send_items(64, FILL_RANDOM);
    wait_idle();
    // steps change mid block; the later steps apply to the whole block
    write_reg(CFG_QUALITY, 7'd30);
    write_reg(CFG_DIR, 7'd0);
    send_items(32, FILL_EXTREME);
    write_reg(CFG_QUALITY, 7'd80);
    send_items(32, FILL_RANDOM);
    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
rtl/dctq_pkg.sv
rtl/dctq_div.sv
rtl/dct8x8_quantizer_codec.sv
tb/tb.sv
